// ----- src/sms_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sms_pkg
// Shared types, sizes and exp constants of the softmax regression unit.
// ----------------------------------------------------------------------------
package sms_pkg;

  localparam int NIn = 6;
  localparam int NOut = 2;

  localparam int CntMax = (NIn + 1 > 20) ? NIn + 1 : 20;
  localparam int CntW = $clog2(CntMax + 1);
  localparam int FiW = (NIn > 1) ? $clog2(NIn) : 1;
  localparam int PosW = $clog2(NIn + 1);
  localparam int ClsW = (NOut > 1) ? $clog2(NOut) : 1;

  localparam logic [23:0] StepReset = 24'd655;

  typedef struct packed {
    logic              operation;
    logic signed [15:0] feature_value;
    logic              last_feature;
    logic [3:0]        target_class;
  } item_t;

  typedef struct packed {
    logic [3:0]  class_index;
    logic [15:0] probability;
    logic        last_class;
  } result_t;

  typedef enum logic [3:0] {
    CmdNone    = 4'd0,
    CmdRead    = 4'd1,
    CmdMul     = 4'd2,
    CmdAcc     = 4'd3,
    CmdLogit   = 4'd4,
    CmdExpInit = 4'd5,
    CmdExpStep = 4'd6,
    CmdDivInit = 4'd7,
    CmdDivStep = 4'd8,
    CmdGrad    = 4'd9,
    CmdUpdMul  = 4'd10,
    CmdUpdAdd  = 4'd11,
    CmdClear   = 4'd12
  } cell_cmd_e;

  typedef struct packed {
    cell_cmd_e          cmd;
    logic [CntW-1:0]    idx;
    logic signed [15:0] feature;
    logic [3:0]         target_class;
    logic [23:0]        step;
  } cell_ctrl_t;

  // exp(-2^(b-16)) in Q0.30 for bit b of a Q16.16 magnitude
  function automatic logic [29:0] exp_const(input logic [4:0] b);
    logic [29:0] c;
    case (b)
      5'd19:   c = 30'd360200;
      5'd18:   c = 30'd19666268;
      5'd17:   c = 30'd145315154;
      5'd16:   c = 30'd395007542;
      5'd15:   c = 30'd651257337;
      5'd14:   c = 30'd836230973;
      5'd13:   c = 30'd947573834;
      5'd12:   c = 30'd1008687096;
      5'd11:   c = 30'd1040706260;
      5'd10:   c = 30'd1057095000;
      5'd9:    c = 30'd1065385899;
      5'd8:    c = 30'd1069555701;
      5'd7:    c = 30'd1071646719;
      5'd6:    c = 30'd1072693760;
      5'd5:    c = 30'd1073217664;
      5'd4:    c = 30'd1073479712;
      5'd3:    c = 30'd1073610760;
      5'd2:    c = 30'd1073676290;
      5'd1:    c = 30'd1073709056;
      5'd0:    c = 30'd1073725440;
      default: c = 30'd0;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- src/sms_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sms_cell
// One class: weights, bias, logit, exp, division and update, with running
// max and running sum handed to the next cell every cycle.
// ----------------------------------------------------------------------------
module sms_cell (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire sms_pkg::cell_ctrl_t ctrl_i,
  input  wire logic [3:0]         class_id_i,
  input  wire logic signed [47:0] max_i,
  output logic signed [47:0]      max_o,
  input  wire logic [34:0]        sum_i,
  output logic [34:0]             sum_o,
  input  wire logic signed [47:0] zmax_i,
  input  wire logic [34:0]        sum_tot_i,
  output logic [15:0]             prob_o
);
  import sms_pkg::*;

  logic signed [31:0] w_mem [NIn];
  logic [NIn-1:0]     w_vld_q;
  logic signed [31:0] wr_q;
  logic signed [31:0] b_q;
  logic signed [47:0] acc_q, prod_q, z_q, max_q;
  logic [30:0]        e_q;
  logic [19:0]        n_q;
  logic [34:0]        sum_q;
  logic [51:0]        rem_q;
  logic [16:0]        quo_q;
  logic signed [41:0] g_q;
  logic signed [56:0] up_q;

  logic [FiW-1:0]     widx;
  logic signed [47:0] n_full;
  logic [60:0]        e_prod;
  logic [52:0]        trial;
  logic signed [17:0] dy;
  logic signed [33:0] wsum;
  logic signed [31:0] wsat;
  logic               is_bias;

  assign widx    = ctrl_i.idx[FiW-1:0];
  assign is_bias = (ctrl_i.idx == CntW'(NIn));
  assign n_full  = zmax_i - z_q;
  assign e_prod  = 61'(e_q) * 61'(exp_const(ctrl_i.idx[4:0]));
  assign trial   = {1'b0, rem_q} - (53'(sum_tot_i) << ctrl_i.idx[4:0]);
  assign prob_o  = quo_q[16] ? 16'hFFFF : quo_q[15:0];
  assign dy      = ((ctrl_i.target_class == class_id_i) ? 18'sd65536 : 18'sd0)
                   - $signed({2'b00, prob_o});
  assign wsum    = 34'(is_bias ? b_q : wr_q) + 34'($signed(up_q[56:24]));
  always_comb begin
    if (wsum > 34'sh07FFFFFFF) begin
      wsat = 32'sh7FFFFFFF;
    end else if (wsum < -34'sh080000000) begin
      wsat = 32'sh80000000;
    end else begin
      wsat = wsum[31:0];
    end
  end

  assign max_o = max_q;
  assign sum_o = sum_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.cmd == CmdUpdAdd && !is_bias) begin
      w_mem[widx] <= wsat;
    end
    if (ctrl_i.cmd == CmdRead) begin
      wr_q <= w_vld_q[widx] ? w_mem[widx] : 32'sd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_vld_q <= '0;
      b_q     <= '0;
      acc_q   <= '0;
      max_q   <= '0;
      sum_q   <= '0;
    end else begin
      max_q <= (z_q > max_i) ? z_q : max_i;
      sum_q <= sum_i + 35'(e_q);
      case (ctrl_i.cmd)
        CmdAcc:   acc_q <= acc_q + prod_q;
        CmdClear: acc_q <= '0;
        CmdUpdAdd: begin
          if (is_bias) begin
            b_q <= wsat;
          end else begin
            w_vld_q[widx] <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (ctrl_i.cmd)
      CmdMul:   prod_q <= 48'(wr_q) * 48'(ctrl_i.feature);
      CmdLogit: z_q <= acc_q + 48'(b_q);
      CmdExpInit: begin
        n_q <= n_full[19:0];
        e_q <= (n_full[47:20] != '0) ? 31'd0 : 31'h40000000;
      end
      CmdExpStep: begin
        if (n_q[ctrl_i.idx[4:0]]) begin
          e_q <= e_prod[60:30];
        end
      end
      CmdDivInit: begin
        rem_q <= 52'(e_q) << 16;
        quo_q <= '0;
      end
      CmdDivStep: begin
        if (!trial[52]) begin
          rem_q <= trial[51:0];
          quo_q[ctrl_i.idx[4:0]] <= 1'b1;
        end
      end
      CmdGrad:   g_q <= 42'($signed({1'b0, ctrl_i.step})) * 42'(dy);
      CmdUpdMul: up_q <= 57'(g_q) * 57'(ctrl_i.feature);
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ----- src/softmax_regression_sgd_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// softmax_regression_sgd_unit
// Softmax classifier with online gradient training over a row of class cells.
//
//   channel  signals                          transfer
//   item     start, busy, item_i              start & !busy
//   result   res_valid_o, res_o               res_valid_o (one cycle)
//   config   cfg_valid_i, cfg_ready_o, cfg_data_i  cfg_valid_i & cfg_ready_o
//
// A feature that is stored passes through weight read, multiply and add.
// A last item then runs the max chain, bit-serial exp, sum chain and
// restoring division, emits one result per class and, on a train item,
// runs the weight update.
// Reset clears weights, bias and counters at once; the receiver cannot stall.
// ----------------------------------------------------------------------------
module softmax_regression_sgd_unit (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output logic                 busy,
  input  wire sms_pkg::item_t  item_i,
  output logic                 res_valid_o,
  output sms_pkg::result_t     res_o,
  input  wire logic            cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire logic [23:0]     cfg_data_i
);
  import sms_pkg::*;

  typedef enum logic [15:0] {
    StIdle = 16'h0001, StFRd  = 16'h0002, StMul  = 16'h0004, StAcc  = 16'h0008,
    StLog  = 16'h0010, StMax  = 16'h0020, StExpI = 16'h0040, StExpS = 16'h0080,
    StSum  = 16'h0100, StDivI = 16'h0200, StDivS = 16'h0400, StEmit = 16'h0800,
    StGrad = 16'h1000, StURd  = 16'h2000, StUMul = 16'h4000, StUAdd = 16'h8000
  } state_e;

  state_e             state_q, state_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [PosW-1:0]    pos_q, pos_d;
  logic [23:0]        step_q;
  item_t              item_q;
  logic signed [15:0] fs_mem [NIn];
  logic signed [15:0] fsr_q;
  logic               clr_q, clr_d;
  cell_ctrl_t         ctrl;
  logic signed [15:0] upd_feat;

  logic signed [47:0] max_chain [NOut+1];
  logic [34:0]        sum_chain [NOut+1];
  logic [15:0]        prob [NOut];

  logic               accept;

  assign accept      = start && !busy;
  assign busy        = (state_q != StIdle);
  assign cfg_ready_o = 1'b1;

  assign max_chain[0] = 48'sh800000000000;
  assign sum_chain[0] = '0;

  for (genvar k = 0; k < NOut; k++) begin : g_cell
    sms_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .class_id_i(4'(k)),
      .max_i     (max_chain[k]),
      .max_o     (max_chain[k+1]),
      .sum_i     (sum_chain[k]),
      .sum_o     (sum_chain[k+1]),
      .zmax_i    (max_chain[NOut]),
      .sum_tot_i (sum_chain[NOut]),
      .prob_o    (prob[k])
    );
  end

  always_comb begin
    if (cnt_q == CntW'(NIn)) begin
      upd_feat = 16'sd1;
    end else if (CntW'(pos_q) > cnt_q) begin
      upd_feat = fsr_q;
    end else begin
      upd_feat = 16'sd0;
    end
  end

  always_comb begin
    state_d           = state_q;
    cnt_d             = cnt_q;
    pos_d             = pos_q;
    clr_d             = 1'b0;
    ctrl.cmd          = CmdNone;
    ctrl.idx          = cnt_q;
    ctrl.feature      = item_q.feature_value;
    ctrl.target_class = item_q.target_class;
    ctrl.step         = step_q;
    if (clr_q) begin
      ctrl.cmd = CmdClear;
    end
    case (state_q)
      StIdle: begin
        if (accept) begin
          if (pos_q < PosW'(NIn)) begin
            state_d = StFRd;
          end else if (item_i.last_feature) begin
            state_d = StLog;
          end
        end
      end
      StFRd: begin
        ctrl.cmd = CmdRead;
        ctrl.idx = CntW'(pos_q);
        state_d  = StMul;
      end
      StMul: begin
        ctrl.cmd = CmdMul;
        state_d  = StAcc;
      end
      StAcc: begin
        ctrl.cmd = CmdAcc;
        pos_d    = pos_q + PosW'(1);
        state_d  = item_q.last_feature ? StLog : StIdle;
      end
      StLog: begin
        ctrl.cmd = CmdLogit;
        cnt_d    = '0;
        state_d  = StMax;
      end
      StMax: begin
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(NOut - 1)) begin
          state_d = StExpI;
        end
      end
      StExpI: begin
        ctrl.cmd = CmdExpInit;
        cnt_d    = CntW'(19);
        state_d  = StExpS;
      end
      StExpS: begin
        ctrl.cmd = CmdExpStep;
        cnt_d    = cnt_q - CntW'(1);
        if (cnt_q == '0) begin
          cnt_d   = '0;
          state_d = StSum;
        end
      end
      StSum: begin
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(NOut - 1)) begin
          state_d = StDivI;
        end
      end
      StDivI: begin
        ctrl.cmd = CmdDivInit;
        cnt_d    = CntW'(16);
        state_d  = StDivS;
      end
      StDivS: begin
        ctrl.cmd = CmdDivStep;
        cnt_d    = cnt_q - CntW'(1);
        if (cnt_q == '0) begin
          cnt_d   = '0;
          state_d = StEmit;
        end
      end
      StEmit: begin
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(NOut - 1)) begin
          cnt_d = '0;
          if (item_q.operation) begin
            state_d = StGrad;
          end else begin
            pos_d   = '0;
            clr_d   = 1'b1;
            state_d = StIdle;
          end
        end
      end
      StGrad: begin
        ctrl.cmd = CmdGrad;
        state_d  = StURd;
      end
      StURd: begin
        ctrl.cmd = CmdRead;
        state_d  = StUMul;
      end
      StUMul: begin
        ctrl.cmd     = CmdUpdMul;
        ctrl.feature = upd_feat;
        state_d      = StUAdd;
      end
      StUAdd: begin
        ctrl.cmd = CmdUpdAdd;
        cnt_d    = cnt_q + CntW'(1);
        state_d  = StURd;
        if (cnt_q == CntW'(NIn)) begin
          cnt_d   = '0;
          pos_d   = '0;
          clr_d   = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      pos_q       <= '0;
      clr_q       <= 1'b0;
      step_q      <= StepReset;
      res_valid_o <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pos_q       <= pos_d;
      clr_q       <= clr_d;
      res_valid_o <= (state_q == StEmit);
      if (cfg_valid_i && cfg_ready_o) begin
        step_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
      if (pos_q < PosW'(NIn)) begin
        fs_mem[pos_q[FiW-1:0]] <= item_i.feature_value;
      end
    end
    if (state_q == StURd) begin
      fsr_q <= fs_mem[cnt_q[FiW-1:0]];
    end
    if (state_q == StEmit) begin
      res_o.class_index <= 4'(cnt_q);
      res_o.probability <= prob[cnt_q[ClsW-1:0]];
      res_o.last_class  <= (cnt_q == CntW'(NOut - 1));
    end
  end

`ifndef ASSERT_OFF
  a_res_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> busy || $past(state_q == StEmit))
    else $error("result outside of a run");
  a_res_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.last_class) |=> !res_valid_o)
    else $error("result after last class");
  a_idle_nores: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFRd) |=> !res_valid_o)
    else $error("result during feature load");
`endif

endmodule
`default_nettype wire
